FILE: rtl/sqas_pkg.sv
// Package with shared types, constants and codes of the argument splitter.
package sqas_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;
    localparam logic [1:0] MODE_ANSI   = 2'd3;

    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_OCT  = 2'd1;
    localparam logic [1:0] NUM_HEX  = 2'd2;

    localparam logic [1:0] BLANK_NONE  = 2'd0;
    localparam logic [1:0] BLANK_SPACE = 2'd1;
    localparam logic [1:0] BLANK_TAB   = 2'd2;

    localparam logic [7:0] ESC_CHAR  = 8'h1B;
    localparam logic [7:0] CTRL_BASE = 8'h40;

    localparam int MAX_RES = 4;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       arg_end;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // One classified item: up to four results and their count.
    typedef struct packed {
        logic [2:0]                 count;
        out_item_t [MAX_RES-1:0]    res;
    } bundle_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c <= 8'h39) t = c - 8'h30;
        else if (c >= 8'h61) t = c - 8'h57;
        else t = c - 8'h37;
        return t[3:0];
    endfunction

endpackage

FILE: rtl/sqas_front.sv
// Front end: parser state machine that turns one character into a result bundle.
module sqas_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sqas_pkg::in_item_t in_data,
    output logic              push,
    output sqas_pkg::bundle_t push_data,
    input  logic              q_full
);

    logic [1:0] quote_mode_reg, quote_mode_next;
    logic       escape_pending_reg, escape_pending_next;
    logic [1:0] number_kind_reg, number_kind_next;
    logic [8:0] number_value_reg, number_value_next;
    logic [1:0] number_digits_reg, number_digits_next;
    logic       control_pending_reg, control_pending_next;
    logic       hex_intro_pending_reg, hex_intro_pending_next;
    logic       dollar_pending_reg, dollar_pending_next;
    logic [1:0] escaped_blank_reg, escaped_blank_next;
    logic       separator_pending_reg, separator_pending_next;
    logic       line_started_reg, line_started_next;

    sqas_pkg::bundle_t b;
    logic       fire;
    logic [7:0] c;
    logic [7:0] up;
    logic [8:0] oct_v;
    logic [1:0] dig;
    logic       fresh;
    logic       ansi_tail;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign c        = in_data.ch;

    // Appends one result to the bundle under construction.
    function automatic sqas_pkg::bundle_t add(input sqas_pkg::bundle_t bi, input logic h,
                                              input logic [7:0] v, input logic e,
                                              input logic [1:0] s);
        sqas_pkg::bundle_t bo;
        bo = bi;
        if (bi.count < 3'(sqas_pkg::MAX_RES))
        begin
            bo.res[bi.count[1:0]].has_byte = h;
            bo.res[bi.count[1:0]].out_byte = v;
            bo.res[bi.count[1:0]].arg_end  = e;
            bo.res[bi.count[1:0]].status   = s;
            bo.res[bi.count[1:0]].last     = 1'b0;
            bo.count = bi.count + 3'd1;
        end
        return bo;
    endfunction

    always_comb
    begin
        quote_mode_next        = quote_mode_reg;
        escape_pending_next    = escape_pending_reg;
        number_kind_next       = number_kind_reg;
        number_value_next      = number_value_reg;
        number_digits_next     = number_digits_reg;
        control_pending_next   = control_pending_reg;
        hex_intro_pending_next = hex_intro_pending_reg;
        dollar_pending_next    = dollar_pending_reg;
        escaped_blank_next     = escaped_blank_reg;
        separator_pending_next = separator_pending_reg;
        line_started_next      = line_started_reg;
        b     = '0;
        fresh = 1'b0;
        ansi_tail = 1'b0;
        up    = (c >= 8'h61) ? c - 8'h20 : c;
        oct_v = {number_value_reg[5:0], 3'b000} + {6'd0, c[2:0]};
        dig   = number_digits_reg + 2'd1;

        if (in_data.action)
        begin
            if (quote_mode_reg == sqas_pkg::MODE_NORMAL)
            begin
                if (dollar_pending_reg) b = add(b, 1'b1, 8'h24, 1'b0, 2'd0);
                b = add(b, 1'b0, 8'h00, line_started_reg, 2'd0);
            end
            else
                b = add(b, 1'b0, 8'h00, 1'b0, quote_mode_reg);
            quote_mode_next        = sqas_pkg::MODE_NORMAL;
            escape_pending_next    = 1'b0;
            number_kind_next       = sqas_pkg::NUM_NONE;
            number_value_next      = '0;
            number_digits_next     = '0;
            control_pending_next   = 1'b0;
            hex_intro_pending_next = 1'b0;
            dollar_pending_next    = 1'b0;
            escaped_blank_next     = sqas_pkg::BLANK_NONE;
            separator_pending_next = 1'b0;
            line_started_next      = 1'b0;
        end
        else
        begin
            case (quote_mode_reg)
                sqas_pkg::MODE_NORMAL:
                begin
                    if (!line_started_reg)
                    begin
                        if (!sqas_pkg::is_blank(c))
                        begin
                            line_started_next = 1'b1;
                            fresh = 1'b1;
                        end
                    end
                    else if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        if (c == 8'h0A) ;
                        else if (c == 8'h20) escaped_blank_next = sqas_pkg::BLANK_SPACE;
                        else if (c == 8'h09) escaped_blank_next = sqas_pkg::BLANK_TAB;
                        else if (c == 8'h24 || c == 8'h27 || c == 8'h22)
                            b = add(b, 1'b1, c, 1'b0, 2'd0);
                        else
                        begin
                            b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                            b = add(b, 1'b1, c, 1'b0, 2'd0);
                        end
                    end
                    else if (dollar_pending_reg && c == 8'h27)
                    begin
                        dollar_pending_next = 1'b0;
                        quote_mode_next = sqas_pkg::MODE_ANSI;
                    end
                    else
                    begin
                        if (dollar_pending_reg)
                        begin
                            dollar_pending_next = 1'b0;
                            b = add(b, 1'b1, 8'h24, 1'b0, 2'd0);
                        end
                        if (sqas_pkg::is_blank(c))
                            separator_pending_next = 1'b1;
                        else
                        begin
                            if (escaped_blank_reg == sqas_pkg::BLANK_SPACE)
                                b = add(b, 1'b1, 8'h20, 1'b0, 2'd0);
                            else if (escaped_blank_reg == sqas_pkg::BLANK_TAB)
                            begin
                                b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                                b = add(b, 1'b1, 8'h09, 1'b0, 2'd0);
                            end
                            escaped_blank_next = sqas_pkg::BLANK_NONE;
                            if (separator_pending_reg)
                            begin
                                b = add(b, 1'b0, 8'h00, 1'b1, 2'd0);
                                separator_pending_next = 1'b0;
                            end
                            fresh = 1'b1;
                        end
                    end
                    if (fresh)
                    begin
                        if (c == 8'h5C) escape_pending_next = 1'b1;
                        else if (c == 8'h27) quote_mode_next = sqas_pkg::MODE_SINGLE;
                        else if (c == 8'h22) quote_mode_next = sqas_pkg::MODE_DOUBLE;
                        else if (c == 8'h24) dollar_pending_next = 1'b1;
                        else b = add(b, 1'b1, c, 1'b0, 2'd0);
                    end
                end
                sqas_pkg::MODE_SINGLE:
                begin
                    if (c == 8'h27) quote_mode_next = sqas_pkg::MODE_NORMAL;
                    else b = add(b, 1'b1, c, 1'b0, 2'd0);
                end
                sqas_pkg::MODE_DOUBLE:
                begin
                    if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        if (c != 8'h22 && c != 8'h5C && c != 8'h0A)
                            b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                        b = add(b, 1'b1, c, 1'b0, 2'd0);
                    end
                    else if (c == 8'h5C) escape_pending_next = 1'b1;
                    else if (c == 8'h22) quote_mode_next = sqas_pkg::MODE_NORMAL;
                    else b = add(b, 1'b1, c, 1'b0, 2'd0);
                end
                default:
                begin
                    if (control_pending_reg)
                    begin
                        control_pending_next = 1'b0;
                        if ((c >= 8'h61 && c <= 8'h7A) || (c >= sqas_pkg::CTRL_BASE && c <= 8'h5F))
                            b = add(b, 1'b1, up - sqas_pkg::CTRL_BASE, 1'b0, 2'd0);
                        else
                        begin
                            b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                            b = add(b, 1'b1, 8'h63, 1'b0, 2'd0);
                            b = add(b, 1'b1, c, 1'b0, 2'd0);
                        end
                    end
                    else if (hex_intro_pending_reg)
                    begin
                        hex_intro_pending_next = 1'b0;
                        if (sqas_pkg::is_hex(c))
                        begin
                            number_kind_next   = sqas_pkg::NUM_HEX;
                            number_value_next  = {5'd0, sqas_pkg::hex_val(c)};
                            number_digits_next = 2'd1;
                        end
                        else
                        begin
                            b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                            b = add(b, 1'b1, 8'h78, 1'b0, 2'd0);
                            ansi_tail = 1'b1;
                        end
                    end
                    else if (number_kind_reg == sqas_pkg::NUM_OCT)
                    begin
                        if (sqas_pkg::is_oct(c))
                        begin
                            number_value_next  = oct_v;
                            number_digits_next = dig;
                            if (dig == 2'd3)
                            begin
                                b = add(b, 1'b1, oct_v[7:0], 1'b0, 2'd0);
                                number_kind_next   = sqas_pkg::NUM_NONE;
                                number_value_next  = '0;
                                number_digits_next = '0;
                            end
                        end
                        else
                        begin
                            b = add(b, 1'b1, number_value_reg[7:0], 1'b0, 2'd0);
                            number_kind_next   = sqas_pkg::NUM_NONE;
                            number_value_next  = '0;
                            number_digits_next = '0;
                            ansi_tail = 1'b1;
                        end
                    end
                    else if (number_kind_reg == sqas_pkg::NUM_HEX)
                    begin
                        number_kind_next   = sqas_pkg::NUM_NONE;
                        number_digits_next = '0;
                        number_value_next  = '0;
                        if (sqas_pkg::is_hex(c))
                            b = add(b, 1'b1, {number_value_reg[3:0], sqas_pkg::hex_val(c)},
                                    1'b0, 2'd0);
                        else
                        begin
                            b = add(b, 1'b1, number_value_reg[7:0], 1'b0, 2'd0);
                            ansi_tail = 1'b1;
                        end
                    end
                    else if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        case (c)
                            8'h61: b = add(b, 1'b1, 8'h07, 1'b0, 2'd0);
                            8'h62: b = add(b, 1'b1, 8'h08, 1'b0, 2'd0);
                            8'h66: b = add(b, 1'b1, 8'h0C, 1'b0, 2'd0);
                            8'h6E: b = add(b, 1'b1, 8'h0A, 1'b0, 2'd0);
                            8'h72: b = add(b, 1'b1, 8'h0D, 1'b0, 2'd0);
                            8'h74: b = add(b, 1'b1, 8'h09, 1'b0, 2'd0);
                            8'h76: b = add(b, 1'b1, 8'h0B, 1'b0, 2'd0);
                            8'h65: b = add(b, 1'b1, sqas_pkg::ESC_CHAR, 1'b0, 2'd0);
                            8'h5C: b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                            8'h27: b = add(b, 1'b1, 8'h27, 1'b0, 2'd0);
                            8'h78: hex_intro_pending_next = 1'b1;
                            8'h63: control_pending_next = 1'b1;
                            default:
                            begin
                                if (sqas_pkg::is_oct(c))
                                begin
                                    number_kind_next   = sqas_pkg::NUM_OCT;
                                    number_value_next  = {6'd0, c[2:0]};
                                    number_digits_next = 2'd1;
                                end
                                else
                                begin
                                    b = add(b, 1'b1, 8'h5C, 1'b0, 2'd0);
                                    b = add(b, 1'b1, c, 1'b0, 2'd0);
                                end
                            end
                        endcase
                    end
                    else
                        ansi_tail = 1'b1;
                    if (ansi_tail)
                    begin
                        if (c == 8'h5C) escape_pending_next = 1'b1;
                        else if (c == 8'h27) quote_mode_next = sqas_pkg::MODE_NORMAL;
                        else b = add(b, 1'b1, c, 1'b0, 2'd0);
                    end
                end
            endcase
        end
    end

    assign push      = fire && (b.count != 3'd0);
    assign push_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_mode_reg        <= sqas_pkg::MODE_NORMAL;
            escape_pending_reg    <= 1'b0;
            number_kind_reg       <= sqas_pkg::NUM_NONE;
            number_value_reg      <= '0;
            number_digits_reg     <= '0;
            control_pending_reg   <= 1'b0;
            hex_intro_pending_reg <= 1'b0;
            dollar_pending_reg    <= 1'b0;
            escaped_blank_reg     <= sqas_pkg::BLANK_NONE;
            separator_pending_reg <= 1'b0;
            line_started_reg      <= 1'b0;
        end
        else if (fire)
        begin
            quote_mode_reg        <= quote_mode_next;
            escape_pending_reg    <= escape_pending_next;
            number_kind_reg       <= number_kind_next;
            number_value_reg      <= number_value_next;
            number_digits_reg     <= number_digits_next;
            control_pending_reg   <= control_pending_next;
            hex_intro_pending_reg <= hex_intro_pending_next;
            dollar_pending_reg    <= dollar_pending_next;
            escaped_blank_reg     <= escaped_blank_next;
            separator_pending_reg <= separator_pending_next;
            line_started_reg      <= line_started_next;
        end
    end

endmodule

FILE: rtl/sqas_queue.sv
// Short queue of result bundles between the front end and the back end.
module sqas_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sqas_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output sqas_pkg::bundle_t head
);

    sqas_pkg::bundle_t [sqas_pkg::QDEPTH-1:0] slot_reg;
    logic [sqas_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [sqas_pkg::QAW:0]   cnt_reg;

    assign full      = (cnt_reg == (sqas_pkg::QAW+1)'(sqas_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{sqas_pkg::QAW{1'b0}}, push} - {{sqas_pkg::QAW{1'b0}}, pop};
        end
    end

endmodule

FILE: rtl/sqas_back.sv
// Back end: unrolls each queued bundle into single results on the output register.
module sqas_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sqas_pkg::bundle_t  q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sqas_pkg::out_item_t out_data
);

    logic [1:0]          idx_reg;
    logic                ov_reg;
    sqas_pkg::out_item_t od_reg;
    sqas_pkg::out_item_t pick;
    logic                load;
    logic                is_last;

    assign load    = q_valid && (!ov_reg || out_ready);
    assign is_last = ({1'b0, idx_reg} + 3'd1) == q_head.count;
    assign q_pop   = load && is_last;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // The selected result, marked as last when it closes its bundle.
    always_comb
    begin
        pick      = q_head.res[idx_reg];
        pick.last = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (load) od_reg <= pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (load) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (load) idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

FILE: rtl/shell_quote_argument_splitter_core.sv
// Top level of the shell-style command line argument splitter.
// Order: a character's first result is written to a queue slot, then to the output register.
// Throughput: one character per cycle while each yields at most one result and
// out_ready is high; an item's results leave the single output register in turn,
// and the four-entry bundle queue absorbs short bursts before in_ready drops.
// Reset: rst_n clears parser state, queue pointers and the output valid at once.
module shell_quote_argument_splitter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sqas_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sqas_pkg::out_item_t out_data
);

    // The front end classifies each transaction into a bundle of results.
    logic              push, full, not_empty, pop;
    sqas_pkg::bundle_t push_data, head;

    sqas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (full)
    );

    // The queue lets the parser run ahead while the output stalls.
    sqas_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // The back end emits one result transaction per cycle while results are queued and out_ready is high.
    sqas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_head    (head),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/sqas_checker.sv
// Port-level checker for the argument splitter, bound to the top level.
module sqas_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input sqas_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input sqas_pkg::out_item_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != 2'd0 |-> !out_data.has_byte && !out_data.arg_end)
        else $error("error status mixed with data");

    a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.arg_end |-> !out_data.has_byte)
        else $error("argument end carries a byte");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != 2'd0 |-> out_data.last)
        else $error("error status not last");

endmodule

bind shell_quote_argument_splitter_core sqas_checker u_sqas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: verif/tb.sv
// Self-checking testbench for the shell-style argument splitter core.
`timescale 1ns / 1ps

module tb;

    // Clock, reset and the two handshake channels of the block.
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    sqas_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    sqas_pkg::out_item_t out_data;

    shell_quote_argument_splitter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The predictor keeps its own copy of the parser state.
    logic [1:0] p_mode;
    logic       p_esc;
    logic [1:0] p_num_kind;
    logic [8:0] p_num_val;
    logic [1:0] p_num_digits;
    logic       p_ctrl;
    logic       p_hex_intro;
    logic       p_dollar;
    logic [1:0] p_blank;
    logic       p_sep;
    logic       p_started;

    // Results of the item being predicted, and the queue of expected results.
    sqas_pkg::out_item_t step_res[$];
    sqas_pkg::out_item_t expected_q[$];

    int  errors;
    int  sent;
    bit  quiet_phase;     // no idling on either side near the end
    bit  long_hold;       // receiver stalls for a long stretch

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic bit blank_ch(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A;
    endfunction

    function automatic bit oct_ch(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic bit hex_ch(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        if (c <= "9") t = c - "0";
        else if (c >= "a") t = c - "a" + 8'd10;
        else t = c - "A" + 8'd10;
        return t[3:0];
    endfunction

    task automatic put_res(input logic h, input logic [7:0] b, input logic e,
                           input logic [1:0] st);
        sqas_pkg::out_item_t r;
        if (step_res.size() >= sqas_pkg::MAX_RES) return;
        r.has_byte = h;
        r.out_byte = b;
        r.arg_end  = e;
        r.status   = st;
        r.last     = 1'b0;
        step_res.insert(step_res.size(), r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_res(1'b1, b, 1'b0, 2'd0);
    endtask

    task automatic clear_parser();
        p_mode = sqas_pkg::MODE_NORMAL; p_esc = 1'b0; p_num_kind = sqas_pkg::NUM_NONE;
        p_num_val = '0; p_num_digits = '0; p_ctrl = 1'b0; p_hex_intro = 1'b0;
        p_dollar = 1'b0; p_blank = sqas_pkg::BLANK_NONE; p_sep = 1'b0; p_started = 1'b0;
    endtask

    // Start of a token outside quotes: opens a quote, an escape, a dollar or
    // is a plain byte.
    task automatic unquoted_start(input logic [7:0] c);
        if (c == "\\") p_esc = 1'b1;
        else if (c == "'") p_mode = sqas_pkg::MODE_SINGLE;
        else if (c == "\"") p_mode = sqas_pkg::MODE_DOUBLE;
        else if (c == "$") p_dollar = 1'b1;
        else put_byte(c);
    endtask

    task automatic unquoted_char(input logic [7:0] c);
        if (!p_started)
        begin
            if (!blank_ch(c))
            begin
                p_started = 1'b1;
                unquoted_start(c);
            end
            return;
        end
        if (p_esc)
        begin
            p_esc = 1'b0;
            if (c == " ")
                p_blank = sqas_pkg::BLANK_SPACE;
            else if (c == 8'h09)
                p_blank = sqas_pkg::BLANK_TAB;
            else if (c == "$" || c == "'" || c == "\"")
                put_byte(c);
            else if (c != 8'h0A)
            begin
                put_byte("\\");
                put_byte(c);
            end
            return;
        end
        if (p_dollar)
        begin
            p_dollar = 1'b0;
            if (c == "'")
            begin
                p_mode = sqas_pkg::MODE_ANSI;
                return;
            end
            put_byte("$");
        end
        if (blank_ch(c))
        begin
            p_sep = 1'b1;
            return;
        end
        // An escaped blank is only emitted once it is known not to trail.
        if (p_blank == sqas_pkg::BLANK_SPACE)
            put_byte(" ");
        else if (p_blank == sqas_pkg::BLANK_TAB)
        begin
            put_byte("\\");
            put_byte(8'h09);
        end
        p_blank = sqas_pkg::BLANK_NONE;
        if (p_sep)
        begin
            put_res(1'b0, 8'h00, 1'b1, 2'd0);
            p_sep = 1'b0;
        end
        unquoted_start(c);
    endtask

    task automatic double_char(input logic [7:0] c);
        if (p_esc)
        begin
            p_esc = 1'b0;
            if (c != "\"" && c != "\\" && c != 8'h0A) put_byte("\\");
            put_byte(c);
        end
        else if (c == "\\") p_esc = 1'b1;
        else if (c == "\"") p_mode = sqas_pkg::MODE_NORMAL;
        else put_byte(c);
    endtask

    task automatic ansi_letter(input logic [7:0] c);
        case (c)
            "a": put_byte(8'h07);
            "b": put_byte(8'h08);
            "f": put_byte(8'h0C);
            "n": put_byte(8'h0A);
            "r": put_byte(8'h0D);
            "t": put_byte(8'h09);
            "v": put_byte(8'h0B);
            "e": put_byte(sqas_pkg::ESC_CHAR);
            "\\": put_byte("\\");
            "'": put_byte("'");
            "x": p_hex_intro = 1'b1;
            "c": p_ctrl = 1'b1;
            default:
                if (oct_ch(c))
                begin
                    p_num_kind   = sqas_pkg::NUM_OCT;
                    p_num_val    = {6'd0, c[2:0]};
                    p_num_digits = 2'd1;
                end
                else
                begin
                    put_byte("\\");
                    put_byte(c);
                end
        endcase
    endtask

    task automatic ansi_char(input logic [7:0] c);
        logic [7:0] u;
        if (p_ctrl)
        begin
            p_ctrl = 1'b0;
            if ((c >= "a" && c <= "z") || (c >= sqas_pkg::CTRL_BASE && c <= "_"))
            begin
                u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                put_byte(u - sqas_pkg::CTRL_BASE);
            end
            else
            begin
                put_byte("\\");
                put_byte("c");
                put_byte(c);
            end
            return;
        end
        if (p_hex_intro)
        begin
            p_hex_intro = 1'b0;
            if (hex_ch(c))
            begin
                p_num_kind   = sqas_pkg::NUM_HEX;
                p_num_val    = {5'd0, hex_digit(c)};
                p_num_digits = 2'd1;
                return;
            end
            put_byte("\\");
            put_byte("x");
        end
        else if (p_num_kind == sqas_pkg::NUM_OCT)
        begin
            if (oct_ch(c))
            begin
                p_num_val    = (p_num_val << 3) + {6'd0, c[2:0]};
                p_num_digits = p_num_digits + 2'd1;
                if (p_num_digits == 2'd3)
                begin
                    put_byte(p_num_val[7:0]);
                    p_num_kind = sqas_pkg::NUM_NONE; p_num_val = '0; p_num_digits = '0;
                end
                return;
            end
            put_byte(p_num_val[7:0]);
            p_num_kind = sqas_pkg::NUM_NONE; p_num_val = '0; p_num_digits = '0;
        end
        else if (p_num_kind == sqas_pkg::NUM_HEX)
        begin
            p_num_kind = sqas_pkg::NUM_NONE; p_num_digits = '0;
            if (hex_ch(c))
            begin
                put_byte({p_num_val[3:0], hex_digit(c)});
                p_num_val = '0;
                return;
            end
            put_byte(p_num_val[7:0]);
            p_num_val = '0;
        end
        else if (p_esc)
        begin
            p_esc = 1'b0;
            ansi_letter(c);
            return;
        end
        if (c == "\\") p_esc = 1'b1;
        else if (c == "'") p_mode = sqas_pkg::MODE_NORMAL;
        else put_byte(c);
    endtask

    // Works out the results of one accepted transaction and queues them.
    task automatic predict_split(input sqas_pkg::in_item_t it);
        step_res.delete();
        if (it.action)
        begin
            if (p_mode == sqas_pkg::MODE_NORMAL)
            begin
                if (p_dollar) put_byte("$");
                put_res(1'b0, 8'h00, p_started, 2'd0);
            end
            else put_res(1'b0, 8'h00, 1'b0, p_mode);
            clear_parser();
        end
        else
        begin
            case (p_mode)
                sqas_pkg::MODE_NORMAL: unquoted_char(it.ch);
                sqas_pkg::MODE_SINGLE:
                    if (it.ch == "'") p_mode = sqas_pkg::MODE_NORMAL;
                    else put_byte(it.ch);
                sqas_pkg::MODE_DOUBLE: double_char(it.ch);
                default:               ansi_char(it.ch);
            endcase
        end
        if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
        foreach (step_res[i]) expected_q.insert(expected_q.size(), step_res[i]);
    endtask

    // Sender: drives one transaction and holds it until it is accepted. Valid
    // only drops when an idle gap is inserted, so transactions can follow
    // back to back.
    task automatic send_item(input logic act, input logic [7:0] c);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            gap = int'($urandom_range(1, 19));
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{action: act, ch: c};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_split('{action: act, ch: c});
        sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_item(1'b0, s[i]);
    endtask

    // Random line of pool or random bytes, with quote openers mixed in at random.
    task automatic send_random_line();
        int n;
        int k;
        logic [7:0] c;
        logic [7:0] pool [0:19] = '{" ", 8'h09, 8'h0A, "\\", "'", "\"", "$", "x", "c",
                                   "0", "7", "3", "a", "F", "g", "n", "e", "@", "_", "z"};
        n = int'($urandom_range(1, 14));
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                1, 2: send_text("$'");
                3: send_text("\"");
                4: send_text("'");
                default: ;
            endcase
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : pool[$urandom_range(0, 19)];
            send_item(1'b0, c);
        end
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Directed table: text of a line and, where obvious, its expected end-of-line
    // status; the predictor checks every row either way.
    typedef struct {
        string      text;
        bit         eol_only_check;
        logic [1:0] want_status;
    } line_row_t;

    line_row_t dir_rows[] = '{
        '{"", 1, 2'd0},
        '{" \t\n ", 1, 2'd0},
        '{"'abc", 1, 2'd1},
        '{"\"ab", 1, 2'd2},
        '{"$'ab", 1, 2'd3},
        '{"  a\\ b\\\tc\\$\\'\\\"\\\nd\\q  ef\\ ", 0, 2'd0},
        '{"\"x\\\"y\\\\z\\\nw\\q\" $", 0, 2'd0},
        '{"$'\\a\\b\\f\\n\\r\\t\\v\\e\\\\\\'\\q'", 0, 2'd0},
        '{"$'\\101\\777\\7x\\18'", 0, 2'd0},
        '{"$'\\x41\\xg\\x7z\\xF'", 0, 2'd0},
        '{"$'\\ca\\c@\\c_\\cZ\\c1\\c'", 0, 2'd0},
        '{"a$b $ \\", 0, 2'd0}
    };

    // Receiver: random stall bursts, plus one long hold-off.
    initial
    begin
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = int'($urandom_range(1, 19));
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Monitor: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        sqas_pkg::out_item_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", int'(out_data), 0);
            else
            begin
                w = expected_q.pop_front();
                if (out_data.has_byte !== w.has_byte)
                    report_mismatch("has_byte", int'(out_data.has_byte), int'(w.has_byte));
                if (out_data.out_byte !== w.out_byte)
                    report_mismatch("out_byte", int'(out_data.out_byte), int'(w.out_byte));
                if (out_data.arg_end !== w.arg_end)
                    report_mismatch("arg_end", int'(out_data.arg_end), int'(w.arg_end));
                if (out_data.status !== w.status)
                    report_mismatch("status", int'(out_data.status), int'(w.status));
                if (out_data.last !== w.last)
                    report_mismatch("last", int'(out_data.last), int'(w.last));
            end
        end
    end

    // Main sequence: reset, directed lines, edge bytes, a long stall, random lines, drain.
    initial
    begin
        int wait_cycles;
        errors = 0; sent = 0; quiet_phase = 1'b0; long_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            send_text(dir_rows[r].text);
            send_item(1'b1, 8'hFF);
            // The end-of-line result of short rows is typed in directly.
            if (dir_rows[r].eol_only_check &&
                (expected_q.size() == 0 ||
                 expected_q[expected_q.size()-1].status != dir_rows[r].want_status))
                report_mismatch("row status", r, int'(dir_rows[r].want_status));
        end
        // Every bit of the character field, including byte 0 and 255.
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);

        long_hold = 1'b1;
        send_text("$'\\c1\\c1\\c1\\c1\\c1\\c1'");
        send_item(1'b1, 8'h55);

        while (sent < 260) send_random_line();
        quiet_phase = 1'b1;
        while (sent < 320) send_random_line();
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results left over", expected_q.size(), 0);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
